// ----- hdl/integer_pixel_upscaler_unit_macros.svh -----
// Assertion macros for the integer pixel upscaler.
`ifndef INTEGER_PIXEL_UPSCALER_UNIT_MACROS_SVH
`define INTEGER_PIXEL_UPSCALER_UNIT_MACROS_SVH

// condition holds in the same cycle
`define IPU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define IPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ipu_pkg.sv -----
// Package: sizes, codes and word types of the integer pixel upscaler.
package ipu_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_SCALE   = 100;

    localparam int PIX_W       = 24;
    localparam int SCALE_W     = 7;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int PAD_W       = 2;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE     = 2'd0,
        CFG_IN_WIDTH  = 2'd1,
        CFG_IN_HEIGHT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0]   out_pixel;
        logic [SCALE_W-1:0] repeat_res;
        logic [PAD_W-1:0]   pad_bytes;
        logic               row_end;
        logic               frame_end;
        logic               refused;
    } ipu_res_t;

    // front to back: one classified word, pixel taken from the line store when from_store
    typedef struct packed {
        logic     valid;
        logic     from_store;
        ipu_res_t res;
    } ipu_desc_t;

endpackage

// ----- hdl/ipu_ifs.sv -----
// Channel interfaces: input words, result words and configuration writes.
interface ipu_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [ipu_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface ipu_out_if;
    logic                         valid;
    logic                         ready;
    logic [ipu_pkg::PIX_W-1:0]    out_pixel;
    logic [ipu_pkg::SCALE_W-1:0]  repeat_res;
    logic [ipu_pkg::PAD_W-1:0]    pad_bytes;
    logic                         row_end;
    logic                         frame_end;
    logic                         refused;

    modport source (output valid, output out_pixel, output repeat_res, output pad_bytes,
                    output row_end, output frame_end, output refused, input ready);
    modport sink   (input valid, input out_pixel, input repeat_res, input pad_bytes,
                    input row_end, input frame_end, input refused, output ready);
endinterface

interface ipu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ipu_pkg::CFG_IDX_W-1:0]   index;
    logic [ipu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ipu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ipu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/ipu_front.sv -----
// Front end: configuration registers, row/replay control and line-store access.
module ipu_front (
    input  logic                         clk,
    input  logic                         rst_n,
    ipu_in_if.sink                       in_ch,
    ipu_cfg_if.sink                      cfg,
    input  logic                         space,
    output ipu_pkg::ipu_desc_t           desc,
    output logic                         ram_we,
    output logic                         ram_re,
    output logic [ipu_pkg::COL_W-1:0]    ram_addr,
    output logic [ipu_pkg::PIX_W-1:0]    ram_wdata
);

    logic [ipu_pkg::SCALE_W-1:0]  scale_reg;
    logic [ipu_pkg::WIDTH_W-1:0]  in_width_reg;
    logic [ipu_pkg::HEIGHT_W-1:0] in_height_reg;

    logic [ipu_pkg::COL_W-1:0]    column_reg,    column_next;
    logic [ipu_pkg::SCALE_W-1:0]  pass_reg,      pass_next;
    logic                         replaying_reg, replaying_next;
    logic [ipu_pkg::HEIGHT_W-1:0] row_count_reg, row_count_next;

    logic [ipu_pkg::SCALE_W-1:0]  eff_scale;
    logic [ipu_pkg::WIDTH_W-1:0]  eff_width;
    logic [ipu_pkg::HEIGHT_W-1:0] eff_height;
    logic                         last_col;
    logic [ipu_pkg::SCALE_W-1:0]  pass_inc;
    logic [ipu_pkg::HEIGHT_W-1:0] row_inc;
    logic [3:0]                   pad_prod;
    logic                         accept;
    logic                         finish;
    logic                         frame_hit;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= ipu_pkg::SCALE_W'(1);
            in_width_reg  <= ipu_pkg::WIDTH_W'(1);
            in_height_reg <= ipu_pkg::HEIGHT_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (ipu_pkg::cfg_idx_t'(cfg.index))
                ipu_pkg::CFG_SCALE:     scale_reg     <= cfg.data[ipu_pkg::SCALE_W-1:0];
                ipu_pkg::CFG_IN_WIDTH:  in_width_reg  <= cfg.data[ipu_pkg::WIDTH_W-1:0];
                ipu_pkg::CFG_IN_HEIGHT: in_height_reg <= cfg.data[ipu_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero reads as one; oversize scale and width values saturate
    always_comb
    begin
        if (scale_reg == '0)
            eff_scale = ipu_pkg::SCALE_W'(1);
        else if (scale_reg > ipu_pkg::SCALE_W'(ipu_pkg::MAX_SCALE))
            eff_scale = ipu_pkg::SCALE_W'(ipu_pkg::MAX_SCALE);
        else
            eff_scale = scale_reg;

        if (in_width_reg == '0)
            eff_width = ipu_pkg::WIDTH_W'(1);
        else if (in_width_reg > ipu_pkg::WIDTH_W'(ipu_pkg::MAX_WIDTH))
            eff_width = ipu_pkg::WIDTH_W'(ipu_pkg::MAX_WIDTH);
        else
            eff_width = in_width_reg;

        eff_height = (in_height_reg == '0) ? ipu_pkg::HEIGHT_W'(1) : in_height_reg;
    end

    assign last_col  = ipu_pkg::WIDTH_W'(column_reg) >= (eff_width - ipu_pkg::WIDTH_W'(1));
    assign pass_inc  = pass_reg + ipu_pkg::SCALE_W'(1);
    assign row_inc   = row_count_reg + ipu_pkg::HEIGHT_W'(1);
    assign frame_hit = row_inc >= eff_height;
    // (w*s) mod 4 needs only the low two bits of each
    assign pad_prod  = {2'b00, eff_width[1:0]} * {2'b00, eff_scale[1:0]};

    always_comb
    begin
        column_next    = column_reg;
        pass_next      = pass_reg;
        replaying_next = replaying_reg;
        row_count_next = row_count_reg;
        finish         = 1'b0;

        desc            = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_addr        = column_reg;
        ram_wdata       = in_ch.pixel;

        if (accept)
        begin
            if (in_ch.kind == ipu_pkg::KIND_PIXEL)
            begin
                desc.valid = 1'b1;
                if (replaying_reg)
                begin
                    desc.res.refused = 1'b1;
                end
                else
                begin
                    ram_we             = 1'b1;
                    desc.res.out_pixel = in_ch.pixel;
                    desc.res.repeat_res = eff_scale;
                    if (last_col)
                    begin
                        desc.res.row_end = 1'b1;
                        column_next      = '0;
                        if (eff_scale > ipu_pkg::SCALE_W'(1))
                        begin
                            replaying_next = 1'b1;
                            pass_next      = '0;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        column_next = column_reg + ipu_pkg::COL_W'(1);
                    end
                end
            end
            else if (replaying_reg)
            begin
                desc.valid          = 1'b1;
                desc.from_store     = 1'b1;
                ram_re              = 1'b1;
                desc.res.repeat_res = eff_scale;
                if (last_col)
                begin
                    desc.res.row_end = 1'b1;
                    column_next      = '0;
                    if (pass_inc >= eff_scale - ipu_pkg::SCALE_W'(1))
                    begin
                        replaying_next = 1'b0;
                        pass_next      = '0;
                        finish         = 1'b1;
                    end
                    else
                    begin
                        pass_next = pass_inc;
                    end
                end
                else
                begin
                    column_next = column_reg + ipu_pkg::COL_W'(1);
                end
            end
        end

        if (finish)
        begin
            desc.res.frame_end = frame_hit;
            row_count_next     = frame_hit ? '0 : row_inc;
        end

        if (desc.res.row_end)
        begin
            desc.res.pad_bytes = pad_prod[ipu_pkg::PAD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            pass_reg      <= '0;
            replaying_reg <= 1'b0;
            row_count_reg <= '0;
        end
        else
        begin
            column_reg    <= column_next;
            pass_reg      <= pass_next;
            replaying_reg <= replaying_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

// ----- hdl/ipu_back.sv -----
// Back end: waits out the line-store read, then queues result words for the sink.
module ipu_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ipu_pkg::ipu_desc_t         desc,
    input  logic [ipu_pkg::PIX_W-1:0]  ram_rdata,
    output logic                       space,
    ipu_out_if.source                  out_ch
);

    ipu_pkg::ipu_desc_t                stage_reg;
    logic                              stage_valid_reg;
    ipu_pkg::ipu_res_t                 queue_reg [ipu_pkg::QUEUE_DEPTH];
    logic [ipu_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ipu_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ipu_pkg::QUEUE_CNT_W-1:0]   count_reg,  count_next;
    ipu_pkg::ipu_res_t                 push_word;
    ipu_pkg::ipu_res_t                 head;
    logic                              push;
    logic                              pop;

    // the staged word always lands next cycle, so count it as taken already
    assign space = (count_reg + ipu_pkg::QUEUE_CNT_W'(stage_valid_reg))
                   < ipu_pkg::QUEUE_CNT_W'(ipu_pkg::QUEUE_DEPTH);

    always_comb
    begin
        push_word = stage_reg.res;
        if (stage_reg.from_store)
        begin
            push_word.out_pixel = ram_rdata;
        end
    end

    assign push = stage_valid_reg;
    assign pop  = out_ch.valid && out_ch.ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + ipu_pkg::QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + ipu_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + ipu_pkg::QUEUE_CNT_W'(push) - ipu_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= desc.valid;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= desc;
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head              = queue_reg[rd_ptr_reg];
    assign out_ch.valid      = count_reg != '0;
    assign out_ch.out_pixel  = head.out_pixel;
    assign out_ch.repeat_res = head.repeat_res;
    assign out_ch.pad_bytes  = head.pad_bytes;
    assign out_ch.row_end    = head.row_end;
    assign out_ch.frame_end  = head.frame_end;
    assign out_ch.refused    = head.refused;

endmodule

// ----- hdl/integer_pixel_upscaler_unit.sv -----
// Top level of the integer pixel upscaler: front end, line store and result queue.
//
//  channel  dir  payload                                               handshake
//  in_ch    in   kind, pixel                                           valid/ready
//  out_ch   out  out_pixel, repeat_res, pad_bytes, row_end,            valid/ready
//                frame_end, refused
//  cfg      in   index (0 scale, 1 in_width, 2 in_height), data        valid/ready
//
// One word per cycle in and out while in_ch.ready and out_ch.ready stay high; a taken word
// passes the line-store read register, then the four-word result queue.
// Reset is asynchronous; the line store is not cleared and needs no pass.
// in_ch.ready drops only while the queue and the read stage together hold four words.
// cfg.ready is always high.
`include "integer_pixel_upscaler_unit_macros.svh"

module integer_pixel_upscaler_unit (
    input  logic       clk,
    input  logic       rst_n,
    ipu_in_if.sink     in_ch,
    ipu_out_if.source  out_ch,
    ipu_cfg_if.sink    cfg
);

    ipu_pkg::ipu_desc_t               desc;
    logic                             space;
    logic                             ram_we;
    logic                             ram_re;
    logic [ipu_pkg::COL_W-1:0]        ram_addr;
    logic [ipu_pkg::PIX_W-1:0]        ram_wdata;
    logic [ipu_pkg::PIX_W-1:0]        ram_rdata;

    ipu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .space     (space),
        .desc      (desc),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata)
    );

    ipu_ram #(
        .WIDTH (ipu_pkg::PIX_W),
        .DEPTH (ipu_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    ipu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc      (desc),
        .ram_rdata (ram_rdata),
        .space     (space),
        .out_ch    (out_ch)
    );

    `IPU_ASSERT_SAME(a_desc_from_accept, desc.valid, in_ch.valid && in_ch.ready, "word queued without an accepted input")
    `IPU_ASSERT_SAME(a_refused_empty, out_ch.valid && out_ch.refused, out_ch.repeat_res == '0 && !out_ch.row_end && out_ch.pad_bytes == '0, "refused word carries payload")
    `IPU_ASSERT_SAME(a_pad_at_row_end, out_ch.valid && out_ch.pad_bytes != '0, out_ch.row_end, "pad bytes outside a row end")
    `IPU_ASSERT_SAME(a_store_one_access, ram_re, !ram_we, "line-store read and write together")

endmodule
